FILE: hdl/dpmd_pkg.sv
`timescale 1ns / 1ps
package dpmd_pkg;

  // Sizes fixed by the register map and the pixel format
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 4096;
  localparam int CH_W          = 8;
  localparam int PIX_W         = 3 * CH_W;
  localparam int THR_W         = 8;
  localparam int FW_W          = 12;
  localparam int FH_W          = 13;
  localparam int ROW_W         = 13;
  // width <= 4095 and height <= 4096, so width*height < 2**24
  localparam int CNT_W         = 24;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [ROW_W-1:0] ROW_LIMIT = 13'd8191;

  // APB
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  localparam logic [THR_W-1:0] RST_THRESHOLD = 8'd70;
  localparam logic [FW_W-1:0]  RST_WIDTH     = 12'd640;
  localparam logic [FH_W-1:0]  RST_HEIGHT    = 13'd480;
  localparam logic [CNT_W-1:0] RST_TOTAL     = 24'd307200;

  typedef struct packed {
    logic [THR_W-1:0] dark_threshold;
    logic [FW_W-1:0]  frame_width;
    logic [FH_W-1:0]  frame_height;
  } cfg_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic             emit;
    logic             eol;
    logic             eof;
    logic             mark;
    logic             up1_ok;
    logic             up2_ok;
    logic [PIX_W-1:0] pix;
  } cmd_t;

endpackage

FILE: hdl/dpmd_rem.sv
`timescale 1ns / 1ps
module dpmd_rem #(
  parameter int DIVIDEND_W = dpmd_pkg::CNT_W,
  parameter int DIVISOR_W  = dpmd_pkg::FW_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  running;
  logic [STEP_W-1:0]     step;
  logic [DIVIDEND_W-1:0] shreg;
  logic [DIVISOR_W-1:0]  d;
  logic [DIVISOR_W-1:0]  r;
  logic [DIVISOR_W:0]    trial;

  // restoring remainder, one dividend bit per cycle
  assign trial     = {r, shreg[DIVIDEND_W-1]};
  assign busy      = running || done;
  assign remainder = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= STEP_W'(DIVIDEND_W - 1);
      end else if (running) begin
        step <= step - STEP_W'(1);
        if (step == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      d     <= divisor;
      r     <= '0;
    end else if (running) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, d}) begin
        r <= DIVISOR_W'(trial - {1'b0, d});
      end else begin
        r <= trial[DIVISOR_W-1:0];
      end
    end
  end

endmodule

FILE: hdl/dpmd_front.sv
`timescale 1ns / 1ps
module dpmd_front #(
  parameter int MAX_WIDTH = dpmd_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dpmd_pkg::cfg_t                cfg,
  input  logic                          cfg_wr,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [dpmd_pkg::CH_W-1:0]     pix_b,
  input  logic [dpmd_pkg::CH_W-1:0]     pix_g,
  input  logic [dpmd_pkg::CH_W-1:0]     pix_r,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [$clog2(MAX_WIDTH)-1:0]  q_col,
  output dpmd_pkg::cmd_t                q_cmd
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W = dpmd_pkg::CNT_W;
  localparam int ROW_W = dpmd_pkg::ROW_W;
  localparam int FW_W  = dpmd_pkg::FW_W;
  localparam int FH_W  = dpmd_pkg::FH_W;
  localparam int PR_W  = WW + FH_W;

  logic [CW-1:0]    in_column;
  logic [ROW_W-1:0] in_row;
  logic [CNT_W-1:0] emitted;
  logic [CW-1:0]    out_col;
  logic [CNT_W-1:0] total;
  logic             recalc;

  logic [WW-1:0]    w;
  logic [WW-1:0]    w_m1;
  logic [FH_W-1:0]  h;
  logic [FH_W-1:0]  h_m1;
  logic [CW-1:0]    col;
  logic [WW-1:0]    col_ext;
  logic [WW-1:0]    col_inc;
  logic             wrap;
  logic             mark;
  logic             emit;
  logic             eol;
  logic             eof;
  logic [CNT_W:0]   emitted_inc;
  logic [PR_W-1:0]  area;
  logic             accept;
  logic             rem_start;
  logic             rem_busy;
  logic             rem_done;
  logic [WW-1:0]    rem_value;
  logic [dpmd_pkg::THR_W-1:0] th;

  // width and height saturated to their legal ranges
  always_comb begin
    if (cfg.frame_width < FW_W'(3)) begin
      w = WW'(3);
    end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg.frame_width);
    end
  end

  always_comb begin
    if (cfg.frame_height < FH_W'(3)) begin
      h = FH_W'(3);
    end else if (32'(cfg.frame_height) > dpmd_pkg::MAX_HEIGHT) begin
      h = FH_W'(dpmd_pkg::MAX_HEIGHT);
    end else begin
      h = cfg.frame_height;
    end
  end

  assign w_m1 = w - WW'(1);
  assign h_m1 = h - FH_W'(1);
  assign th   = cfg.dark_threshold;

  // a column left past a narrowed width acts as the last column
  assign col     = (WW'(in_column) < w) ? in_column : CW'(w_m1);
  assign col_ext = WW'(col);
  assign col_inc = col_ext + WW'(1);
  assign wrap    = col_inc >= w;

  assign mark = !func && (pix_b < th) && (pix_g < th) && (pix_r < th) &&
                (in_row != '0) && (in_row < h_m1) &&
                (col != '0) && (col_ext < w_m1);

  assign emit = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (col != '0));

  assign emitted_inc = {1'b0, emitted} + (CNT_W + 1)'(1);
  assign eof         = emitted_inc >= {1'b0, total};
  assign eol         = WW'(out_col) == w_m1;

  assign accept   = in_valid && in_ready;
  assign in_ready = !recalc && !rem_busy && !q_full;

  assign q_push        = accept;
  assign q_col         = col;
  assign q_cmd.emit    = emit;
  assign q_cmd.eol     = eol;
  assign q_cmd.eof     = eof;
  assign q_cmd.mark    = mark;
  assign q_cmd.up1_ok  = in_row != '0;
  assign q_cmd.up2_ok  = in_row >= ROW_W'(2);
  assign q_cmd.pix     = func ? '0 : {pix_r, pix_g, pix_b};

  assign area      = PR_W'(w) * PR_W'(h);
  assign rem_start = recalc && !rem_busy;

  // rebuilds the output column (emitted mod width) after a register write
  dpmd_rem #(
    .DIVIDEND_W (CNT_W),
    .DIVISOR_W  (WW)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (emitted),
    .divisor   (w),
    .busy      (rem_busy),
    .done      (rem_done),
    .remainder (rem_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      emitted   <= '0;
      out_col   <= '0;
      total     <= dpmd_pkg::RST_TOTAL;
      recalc    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        recalc <= 1'b1;
      end else if (rem_start) begin
        recalc <= 1'b0;
      end
      if (rem_start) begin
        total <= CNT_W'(area);
      end
      priority if (accept) begin
        if (emit && eof) begin
          in_column <= '0;
          in_row    <= '0;
          emitted   <= '0;
          out_col   <= '0;
        end else begin
          if (emit) begin
            emitted <= emitted + CNT_W'(1);
            out_col <= eol ? '0 : out_col + CW'(1);
          end
          if (wrap) begin
            in_column <= '0;
            if (in_row != dpmd_pkg::ROW_LIMIT) begin
              in_row <= in_row + ROW_W'(1);
            end
          end else begin
            in_column <= CW'(col_inc);
          end
        end
      end else if (rem_done) begin
        out_col <= CW'(rem_value);
      end
    end
  end

  a_out_col_in_line: assert property (@(posedge clk) disable iff (rst)
    (!recalc && !rem_busy) |-> (WW'(out_col) < w))
    else $error("output column outside the line");

  a_rem_on_request: assert property (@(posedge clk) disable iff (rst)
    $rose(rem_busy) |-> $past(recalc))
    else $error("remainder unit started without a pending register write");

endmodule

FILE: hdl/dpmd_fifo.sv
`timescale 1ns / 1ps
module dpmd_fifo #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = dpmd_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = count == CNT_W'(DEPTH);
  assign valid = count != '0;
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("word pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !valid |-> !pop)
    else $error("word popped from an empty queue");

endmodule

FILE: hdl/dpmd_back.sv
`timescale 1ns / 1ps
module dpmd_back #(
  parameter int MAX_WIDTH = dpmd_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
  input  dpmd_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dpmd_pkg::CH_W-1:0]     out_b,
  output logic [dpmd_pkg::CH_W-1:0]     out_g,
  output logic [dpmd_pkg::CH_W-1:0]     out_r,
  output logic                          end_of_line,
  output logic                          end_of_frame
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int PIX_W = dpmd_pkg::PIX_W;
  localparam int CH_W  = dpmd_pkg::CH_W;

  // line buffers: marks of two lines above, pixels of the line above
  logic [1:0]       flag_mem [MAX_WIDTH];
  logic [PIX_W-1:0] pix_mem  [MAX_WIDTH];

  logic             s1_valid;
  logic [CW-1:0]    s1_col;
  dpmd_pkg::cmd_t   s1_cmd;
  logic [1:0]       flag_rd;
  logic [PIX_W-1:0] pix_rd;
  logic             byp;
  logic [1:0]       byp_flag;
  logic [PIX_W-1:0] byp_pix;
  logic [8:0]       win;
  logic [8:0]       win_next;
  logic [PIX_W-1:0] c1;

  logic             retire;
  logic [1:0]       flag_eff;
  logic [PIX_W-1:0] pix_eff;
  logic             up1;
  logic             up2;
  logic [1:0]       flag_wdata;
  logic [PIX_W-1:0] pix_out;

  assign retire = s1_valid && (!s1_cmd.emit || !out_valid || out_ready);
  assign q_pop  = q_valid && (!s1_valid || retire);

  // same column read right after it was written: take the write data
  assign flag_eff   = byp ? byp_flag : flag_rd;
  assign pix_eff    = byp ? byp_pix : pix_rd;
  assign up1        = s1_cmd.up1_ok & flag_eff[0];
  assign up2        = s1_cmd.up2_ok & flag_eff[1];
  assign flag_wdata = {up1, s1_cmd.mark};
  assign win_next   = {win[5:0], s1_cmd.mark, up1, up2};
  assign pix_out    = (win_next != '0) ? '0 : c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      win       <= '0;
      c1        <= '0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (retire) begin
        s1_valid <= 1'b0;
      end
      if (retire) begin
        win <= win_next;
        c1  <= pix_eff;
      end
      if (retire && s1_cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_col   <= q_col;
      s1_cmd   <= q_cmd;
      byp      <= retire && (s1_col == q_col);
      byp_flag <= flag_wdata;
      byp_pix  <= s1_cmd.pix;
    end
    if (retire && s1_cmd.emit) begin
      out_b        <= pix_out[CH_W-1:0];
      out_g        <= pix_out[2*CH_W-1:CH_W];
      out_r        <= pix_out[3*CH_W-1:2*CH_W];
      end_of_line  <= s1_cmd.eol;
      end_of_frame <= s1_cmd.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      flag_mem[s1_col] <= flag_wdata;
    end
    if (q_pop) begin
      flag_rd <= flag_mem[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      pix_mem[s1_col] <= s1_cmd.pix;
    end
    if (q_pop) begin
      pix_rd <= pix_mem[q_col];
    end
  end

  a_result_taken: assert property (@(posedge clk) disable iff (rst)
    ($fell(out_valid) && !$past(rst)) |-> $past(out_ready))
    else $error("result dropped from the output register");

endmodule

FILE: hdl/dark_pixel_mask_dilate_3x3_core.sv
`timescale 1ns / 1ps
// Channel  | Handshake          | Payload
// ---------+--------------------+--------------------------------------------------
// apb      | psel/penable/pready| paddr[3:0], pwrite, pwdata[31:0] -> prdata[31:0]
// in       | in_valid/in_ready  | func, pix_b, pix_g, pix_r
// out      | out_valid/out_ready| out_b, out_g, out_r, end_of_line, end_of_frame
//
// One word per clock sustained while the output is not stalled and no register
// write is pending; a word passes the queue, the line-buffer RAM read stage and
// then the output register. After any register write in_ready stays low while the
// output column (emitted count mod width) is rebuilt one bit per cycle.
// Synchronous reset clears counters, window and handshake state; the line
// buffers are not cleared, no sweep after reset.
// A four-word queue splits the classifier from the line-buffer back end, so an
// output stall backs up the queue before in_ready drops.
module dark_pixel_mask_dilate_3x3_core #(
  parameter int MAX_WIDTH = dpmd_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // APB configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dpmd_pkg::PADDR_W-1:0]     paddr,
  input  logic [dpmd_pkg::PDATA_W-1:0]     pwdata,
  output logic [dpmd_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  // pixel words in
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             func,
  input  logic [dpmd_pkg::CH_W-1:0]        pix_b,
  input  logic [dpmd_pkg::CH_W-1:0]        pix_g,
  input  logic [dpmd_pkg::CH_W-1:0]        pix_r,
  // pixel words out
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dpmd_pkg::CH_W-1:0]        out_b,
  output logic [dpmd_pkg::CH_W-1:0]        out_g,
  output logic [dpmd_pkg::CH_W-1:0]        out_r,
  output logic                             end_of_line,
  output logic                             end_of_frame
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int CMD_W  = $bits(dpmd_pkg::cmd_t);
  localparam int WORD_W = CW + CMD_W;
  localparam int PDATA_W = dpmd_pkg::PDATA_W;

  dpmd_pkg::cfg_t cfg;
  logic           cfg_wr;
  logic [1:0]     reg_idx;

  logic              q_push;
  logic              q_full;
  logic [CW-1:0]     f_col;
  dpmd_pkg::cmd_t    f_cmd;
  logic              q_pop;
  logic              q_valid;
  logic [WORD_W-1:0] q_dout;
  logic [CW-1:0]     b_col;
  dpmd_pkg::cmd_t    b_cmd;

  // ---------------------------------------------------------------------------
  // Register file. Always ready; write lands in the access phase.
  // Register i sits at byte address 4*i.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dark_threshold <= dpmd_pkg::RST_THRESHOLD;
      cfg.frame_width    <= dpmd_pkg::RST_WIDTH;
      cfg.frame_height   <= dpmd_pkg::RST_HEIGHT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dpmd_pkg::REG_THRESHOLD: begin
          cfg.dark_threshold <= pwdata[dpmd_pkg::THR_W-1:0];
        end
        dpmd_pkg::REG_WIDTH: begin
          cfg.frame_width <= pwdata[dpmd_pkg::FW_W-1:0];
        end
        dpmd_pkg::REG_HEIGHT: begin
          cfg.frame_height <= pwdata[dpmd_pkg::FH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dpmd_pkg::REG_THRESHOLD: prdata = PDATA_W'(cfg.dark_threshold);
      dpmd_pkg::REG_WIDTH:     prdata = PDATA_W'(cfg.frame_width);
      dpmd_pkg::REG_HEIGHT:    prdata = PDATA_W'(cfg.frame_height);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front: raster position, dark test, emit/end-of-line/end-of-frame decisions.
  // All frame bookkeeping lives here so the next word is classified at once.
  // ---------------------------------------------------------------------------
  dpmd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .pix_b    (pix_b),
    .pix_g    (pix_g),
    .pix_r    (pix_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_col    (f_col),
    .q_cmd    (f_cmd)
  );

  // Queue between the halves: column plus classified word
  dpmd_fifo #(
    .DATA_W (WORD_W),
    .DEPTH  (dpmd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   ({f_col, f_cmd}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  assign b_col = q_dout[WORD_W-1:CMD_W];
  assign b_cmd = q_dout[CMD_W-1:0];

  // ---------------------------------------------------------------------------
  // Back: line-buffer RAMs, 3x3 mark window, centre pixel delay and the
  // output register. A window with any mark blackens the centre pixel.
  // ---------------------------------------------------------------------------
  dpmd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_col        (b_col),
    .q_cmd        (b_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_b        (out_b),
    .out_g        (out_g),
    .out_r        (out_r),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame)
  );

endmodule

FILE: sim/dpmd_tb_pkg.sv
`timescale 1ns / 1ps
package dpmd_tb_pkg;

  // func field of an input word
  typedef enum logic {
    FUNC_PIXEL = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_e;

endpackage

FILE: sim/dark_pixel_mask_dilate_3x3_checker.sv
`timescale 1ns / 1ps
module dark_pixel_mask_dilate_3x3_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [7:0]  pix_b,
  input  logic [7:0]  pix_g,
  input  logic [7:0]  pix_r,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_b,
  input  logic [7:0]  out_g,
  input  logic [7:0]  out_r,
  input  logic        end_of_line,
  input  logic        end_of_frame,
  output int          mismatch_count,
  output int          pending,
  output logic        frame_home
);
  import dpmd_pkg::*;
  import dpmd_tb_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       eol;
    logic       eof;
  } shown_pixel_t;

  shown_pixel_t due_pixels[$];

  logic [THR_W-1:0] thr_reg;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;

  logic [1:0]       flag_lines [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] pix_line   [MAX_WIDTH_DEF];
  logic [8:0]       flag_win;
  logic [PIX_W-1:0] ctr_pix [2];
  int unsigned      pos_col;
  int unsigned      pos_row;
  int unsigned      emitted;

  function automatic int unsigned clip(input int unsigned v, lo, hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // dilated-mask prediction for one accepted word
  task automatic dilate_predict(input logic is_flush, input logic [7:0] b, g, r);
    int unsigned  w, h, col, row, total;
    logic         mark, up1, up2, eof;
    logic [1:0]   old;
    logic [23:0]  pix, shown;
    shown_pixel_t want;
    w   = clip(width_reg, 3, MAX_WIDTH_DEF);
    h   = clip(height_reg, 3, MAX_HEIGHT);
    col = (pos_col < w) ? pos_col : w - 1;
    row = pos_row;
    pix = is_flush ? '0 : {r, g, b};
    mark = !is_flush && b < thr_reg && g < thr_reg && r < thr_reg &&
           row > 0 && row < h - 1 && col > 0 && col < w - 1;

    // marks of lines above the top line are masked off
    old = flag_lines[col];
    up1 = (row >= 1) ? old[0] : 1'b0;
    up2 = (row >= 2) ? old[1] : 1'b0;
    flag_lines[col] = {up1, mark};
    flag_win = {flag_win[5:0], mark, up1, up2};

    ctr_pix[0] = ctr_pix[1];
    ctr_pix[1] = pix_line[col];
    pix_line[col] = pix;

    if (row >= 2 || (row == 1 && col >= 1)) begin
      shown    = (flag_win != 0) ? '0 : ctr_pix[0];
      total    = w * h;
      eof      = (emitted + 1 >= total);
      want.b   = shown[7:0];
      want.g   = shown[15:8];
      want.r   = shown[23:16];
      want.eol = (emitted % w == w - 1);
      want.eof = eof;
      due_pixels.push_back(want);
      if (eof) begin
        emitted = 0;
        pos_row = 0;
        pos_col = 0;
        return;
      end
      emitted++;
    end

    pos_col = col + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      if (pos_row < ROW_LIMIT) pos_row++;
    end
  endtask

  task automatic check_field(input string fname, input int unsigned want, got);
    if (want != got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, fname, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    shown_pixel_t want;
    if (rst) begin
      due_pixels.delete();
      thr_reg    = RST_THRESHOLD;
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      foreach (flag_lines[i]) flag_lines[i] = '0;
      foreach (pix_line[i]) pix_line[i] = '0;
      flag_win   = '0;
      ctr_pix[0] = '0;
      ctr_pix[1] = '0;
      pos_col    = 0;
      pos_row    = 0;
      emitted    = 0;
      mismatch_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_THRESHOLD: thr_reg    = pwdata[THR_W-1:0];
          REG_WIDTH:     width_reg  = pwdata[FW_W-1:0];
          REG_HEIGHT:    height_reg = pwdata[FH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        dilate_predict(func == FUNC_FLUSH, pix_b, pix_g, pix_r);
      if (out_valid && out_ready) begin
        if (due_pixels.size() == 0) begin
          $display("%0t ns: unexpected word expected none actual b=%0h g=%0h r=%0h eol=%0b eof=%0b",
                   $time, out_b, out_g, out_r, end_of_line, end_of_frame);
          mismatch_count++;
        end else begin
          want = due_pixels.pop_front();
          check_field("out_b", want.b, out_b);
          check_field("out_g", want.g, out_g);
          check_field("out_r", want.r, out_r);
          check_field("end_of_line", want.eol, end_of_line);
          check_field("end_of_frame", want.eof, end_of_frame);
        end
      end
    end
    pending    <= due_pixels.size();
    frame_home <= (pos_row == 0 && pos_col == 0);
  end

endmodule

FILE: sim/dark_pixel_mask_dilate_3x3_core_tb.sv
`timescale 1ns / 1ps
module dark_pixel_mask_dilate_3x3_core_tb;
  import dpmd_pkg::*;
  import dpmd_tb_pkg::*;

  localparam int RANDOM_WORDS  = 950;
  // queue depth plus the RAM read stage, with margin
  localparam int SETTLE_CYCLES = 16;
  // cycles with no word moving on either side before we give up
  localparam int STALL_LIMIT   = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func     = FUNC_PIXEL;
  logic [7:0]  pix_b    = '0;
  logic [7:0]  pix_g    = '0;
  logic [7:0]  pix_r    = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_b;
  logic [7:0]  out_g;
  logic [7:0]  out_r;
  logic        end_of_line;
  logic        end_of_frame;

  int          mismatch_count;
  int          pending;
  logic        frame_home;

  // stimulus-side view of the threshold and frame geometry, used only to shape stimulus
  logic [7:0]  cur_thr = 8'd70;
  int unsigned cur_w = 640;
  int unsigned cur_h = 480;
  bit          calm = 1'b0;     // no idling on either side while set
  int          words_sent = 0;
  int          quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dark_pixel_mask_dilate_3x3_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .pix_b(pix_b), .pix_g(pix_g), .pix_r(pix_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_b(out_b), .out_g(out_g), .out_r(out_r),
    .end_of_line(end_of_line), .end_of_frame(end_of_frame)
  );

  // Checker sits on both channels and the config port; it owns the
  // prediction and reports mismatches, queue depth and frame alignment.
  dark_pixel_mask_dilate_3x3_checker chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .pix_b(pix_b), .pix_g(pix_g), .pix_r(pix_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_b(out_b), .out_g(out_g), .out_r(out_r),
    .end_of_line(end_of_line), .end_of_frame(end_of_frame),
    .mismatch_count(mismatch_count), .pending(pending), .frame_home(frame_home)
  );

  // Output backpressure: ~37% stall, none during calm stretches.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 37);
  end

  // Watchdog: any word moving on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned clip(input int unsigned v, lo, hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Dark pixels sit below the threshold on all channels; a quarter of them
  // have one channel exactly on the threshold, so they just miss the mark.
  function automatic logic [23:0] pick_pixel(input int dark_pct);
    logic [7:0] b, g, r;
    if (cur_thr != 0 && $urandom_range(99) < dark_pct) begin
      b = $urandom_range(cur_thr - 1);
      g = $urandom_range(cur_thr - 1);
      r = $urandom_range(cur_thr - 1);
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(2))
          0: b = cur_thr;
          1: g = cur_thr;
          default: r = cur_thr;
        endcase
      end
    end else begin
      {r, g, b} = $urandom;
    end
    return {r, g, b};
  endfunction

  // Present one word and hold it until taken. valid is only dropped on an
  // idle cycle, never between back-to-back words.
  task automatic send_word(input func_e f, input logic [7:0] b, g, r);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    pix_b    <= b;
    pix_g    <= g;
    pix_r    <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_pixel(input logic [23:0] px);
    send_word(FUNC_PIXEL, px[7:0], px[15:8], px[23:16]);
  endtask

  // flush payload is don't-care, so randomize it
  task automatic send_flush();
    send_word(FUNC_FLUSH, $urandom, $urandom, $urandom);
  endtask

  // Stop sending, let every expected word drain, then give the back end
  // time to empty words that produce no output (top line of a frame).
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Feed flush words one at a time until the stream is back at a frame start.
  // frame_home is registered, so it is looked at after each word with valid held low.
  task automatic align_frame();
    in_valid <= 1'b0;
    @(posedge clk);
    while (!frame_home) begin
      send_flush();
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // This task writes the registers only on a frame boundary with the pipe empty.
  task automatic reconfigure(input int unsigned thr, wreg, hreg);
    align_frame();
    settle();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_WIDTH, wreg);
    write_reg(REG_HEIGHT, hreg);
    cur_thr = thr;
    cur_w   = clip(wreg & 12'hFFF, 3, MAX_WIDTH_DEF);
    cur_h   = clip(hreg & 13'h1FFF, 3, MAX_HEIGHT);
  endtask

  // One frame body plus its flush tail. A few flush words land inside the
  // body (black, never marked) and a few pixels land in the tail (treated
  // as flush). tail_adjust < 0 leaves the frame short so the next frame's
  // words finish it; > 0 spills flush words into the next frame.
  task automatic run_frame(input int dark_pct, input int tail_adjust);
    int unsigned body;
    int          tail;
    body = cur_w * cur_h;
    tail = int'(cur_w) + 1 + tail_adjust;
    if (tail < 0) tail = 0;
    repeat (body) begin
      if ($urandom_range(99) < 4) send_flush();
      else send_pixel(pick_pixel(dark_pct));
    end
    repeat (tail) begin
      if ($urandom_range(99) < 15) send_pixel(pick_pixel(dark_pct));
      else send_flush();
    end
  endtask

  // Pause past the first line of a frame, shrink the width (never widen:
  // the line above would hold columns never written) and change the
  // height and threshold, then run the frame out.
  task automatic reshape_mid_frame();
    int unsigned n, nw, nh, nt;
    n  = $urandom_range(cur_w * cur_h - 1, cur_w + 1);
    repeat (n) send_pixel(pick_pixel(15));
    settle();
    nw = $urandom_range(cur_w, 3);
    nh = $urandom_range(8, 3);
    nt = $urandom_range(255);
    write_reg(REG_WIDTH, nw);
    write_reg(REG_HEIGHT, nh);
    write_reg(REG_THRESHOLD, nt);
    cur_w   = nw;
    cur_h   = nh;
    cur_thr = nt;
    align_frame();
  endtask

  initial begin : stimulus
    int phase;
    int random_start;
    int unsigned thr, wreg, hreg;
    int dark_pct;
    int tail_adjust;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed 4x3 frame at threshold 70. Only columns 1..2 of row 1 can be
    // marked: (1,1) is dark and marked, (1,2) misses by its green channel.
    // Dark border pixels must not mark anything.
    reconfigure(70, 4, 3);
    send_pixel({8'd0,   8'd0,   8'd0});     // corner, dark but border
    send_pixel({8'd255, 8'd255, 8'd255});
    send_pixel({8'd69,  8'd69,  8'd69});    // top border, dark
    send_pixel({8'd200, 8'd5,   8'd128});
    send_pixel({8'd0,   8'd0,   8'd70});    // left border, blue on threshold
    send_pixel({8'd69,  8'd69,  8'd69});    // marked
    send_pixel({8'd69,  8'd70,  8'd69});    // green on threshold: not marked
    send_pixel({8'd3,   8'd2,   8'd1});     // right border, dark
    send_flush();                           // flush inside frame
    send_pixel({8'd255, 8'd0,   8'd255});
    send_pixel({8'd0,   8'd0,   8'd0});     // bottom border, dark
    send_pixel({8'd69,  8'd69,  8'd70});
    send_flush();
    send_flush();
    send_pixel({8'd51,  8'd34,  8'd17});    // pixel past the last line
    send_flush();
    send_flush();

    // Random phases: each sets a new geometry and threshold, then runs a
    // few mostly well-formed frames. Phases 0 and 1 pin the low geometry extremes.
    random_start = words_sent;
    phase = 0;
    while (words_sent - random_start < RANDOM_WORDS) begin
      calm = (phase == 4 || phase == 5);
      case ($urandom_range(3))
        0: thr = 0;
        1: thr = 255;
        default: thr = $urandom_range(200, 20);
      endcase
      if ($urandom_range(99) < 10) wreg = $urandom_range(2);
      else if ($urandom_range(99) < 10) wreg = $urandom_range(24, 9);
      else wreg = $urandom_range(8, 3);
      hreg = ($urandom_range(99) < 10) ? $urandom_range(2) : $urandom_range(6, 3);
      if (phase == 0) begin
        thr = 0;
        wreg = 0;
        hreg = 0;
      end else if (phase == 1) begin
        thr = 255;
        wreg = 2;
        hreg = 1;
      end
      reconfigure(thr, wreg, hreg);

      repeat ($urandom_range(3, 1)) begin
        case ($urandom_range(3))
          0: dark_pct = 0;
          1: dark_pct = 5;
          2: dark_pct = 15;
          default: dark_pct = 40;
        endcase
        case ($urandom_range(9))
          0: tail_adjust = -int'($urandom_range(cur_w, 1));
          1: tail_adjust = $urandom_range(3, 1);
          default: tail_adjust = 0;
        endcase
        run_frame(dark_pct, tail_adjust);
      end

      if (phase % 5 == 3) reshape_mid_frame();
      phase++;
    end

    // Upper register extremes, one frame each, without idling: the widest
    // line (clamped to the buffer depth) and the tallest frame.
    calm = 1'b1;
    reconfigure(255, 12'hFFF, 3);
    run_frame(2, 0);
    reconfigure(128, 0, 13'h1FFF);
    run_frame(1, 0);
    calm = 1'b0;

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: dark_pixel_mask_dilate_3x3_core.f
hdl/dpmd_pkg.sv
hdl/dpmd_rem.sv
hdl/dpmd_front.sv
hdl/dpmd_fifo.sv
hdl/dpmd_back.sv
hdl/dark_pixel_mask_dilate_3x3_core.sv
sim/dpmd_tb_pkg.sv
sim/dark_pixel_mask_dilate_3x3_checker.sv
sim/dark_pixel_mask_dilate_3x3_core_tb.sv
